@@ design/tfr_pkg.sv @@
// Shared constants, types and channel expansion functions for the texel
// format converter. No dependencies.
package tfr_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam int PAL_WIDTH = 16;

    localparam logic [3:0] FMT_RGBA16 = 4'd0;
    localparam logic [3:0] FMT_RGBA32 = 4'd1;
    localparam logic [3:0] FMT_IA4    = 4'd2;
    localparam logic [3:0] FMT_IA8    = 4'd3;
    localparam logic [3:0] FMT_IA16   = 4'd4;
    localparam logic [3:0] FMT_CI4    = 4'd5;
    localparam logic [3:0] FMT_CI8    = 4'd6;
    localparam logic [3:0] FMT_I4     = 4'd7;
    localparam logic [3:0] FMT_I8     = 4'd8;

    typedef enum logic [2:0] {
        K_5551,
        K_RGBA32,
        K_IA4,
        K_IA8,
        K_IA16,
        K_I4,
        K_I8,
        K_PAL
    } pix_kind_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    // floor(v * 255 / 31) as 8v + floor(7v / 31), the last term by reciprocal.
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [7:0]  t;
        logic [16:0] q;
        t = {v, 3'b000} - {3'b000, v};
        q = 17'(t) * 17'd265;
        return {v, 3'b000} + {5'b00000, q[15:13]};
    endfunction

    function automatic rgba_t expand(input pix_kind_t kind, input logic [31:0] raw);
        rgba_t      p;
        logic [7:0] v;
        p = '0;
        v = '0;
        case (kind)
            K_5551, K_PAL:
            begin
                p.red   = widen5(raw[15:11]);
                p.green = widen5(raw[10:6]);
                p.blue  = widen5(raw[5:1]);
                p.alpha = {8{raw[0]}};
            end
            K_RGBA32:
            begin
                p = raw;
            end
            K_IA4:
            begin
                v = {raw[3:1], 5'b00000} + {3'b000, raw[3:1], 2'b00};
                p = {v, v, v, {8{raw[0]}}};
            end
            K_IA8:
            begin
                v = {raw[7:4], raw[7:4]};
                p = {v, v, v, raw[3:0], raw[3:0]};
            end
            K_IA16:
            begin
                p = {raw[15:8], raw[15:8], raw[15:8], raw[7:0]};
            end
            K_I4:
            begin
                v = {raw[3:0], raw[3:0]};
                p = {v, v, v, 8'hFF};
            end
            K_I8:
            begin
                p = {raw[7:0], raw[7:0], raw[7:0], 8'hFF};
            end
            default:
            begin
                p = '0;
            end
        endcase
        return p;
    endfunction

endpackage

@@ design/texel_format_to_rgba32.sv @@
// Texel format converter: unpacks texture bytes into RGBA8888 pixels.
// Depends on tfr_pkg and tfr_ram.
// A pixel is registered in stage one, with any palette read, then in the output
// register. Throughput: one pixel beat per cycle unless out_stall holds it;
// four-bit formats give two pixels per byte via the single output register.
// Reset clears the format, byte phase, held bytes and valid flags; palette
// contents are undefined until written.
module texel_format_to_rgba32 (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [3:0]               cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     func,
    input  logic [7:0]               data_byte,
    input  logic                     start_of_image,
    input  logic [7:0]               pal_index,
    input  logic [tfr_pkg::PAL_WIDTH-1:0] pal_color,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    output logic [7:0]               alpha,
    output logic                     last_of_run
);
    import tfr_pkg::*;

    logic [3:0]  format_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [23:0] held_reg;

    logic        s1_valid_reg, s1_two_reg, s1_second_reg;
    pix_kind_t   s1_kind_reg;
    logic [31:0] s1_raw0_reg;
    logic [3:0]  s1_raw1_reg;
    logic        s1_oob0_reg, s1_oob1_reg;

    logic        out_valid_reg;
    rgba_t       out_pix_reg;
    logic        out_last_reg;

    logic        accept, data_item, emit, two;
    pix_kind_t   kind;
    logic [31:0] raw0;
    logic [1:0]  phase_eff;
    logic [7:0]  rd_index_a;
    logic        oob0, oob1;
    logic        out_load, s1_leave, s1_last;
    logic        pal_we;
    logic [PAL_WIDTH-1:0] rdata_a, rdata_b, pal_col;
    logic [31:0] raw_sel;
    rgba_t       pix_sel;

    assign out_load  = !out_valid_reg || !out_stall;
    assign s1_last   = !s1_two_reg || s1_second_reg;
    assign s1_leave  = s1_valid_reg && out_load && s1_last;
    assign in_stall  = s1_valid_reg && !s1_leave;
    assign accept    = in_valid && !in_stall;
    assign data_item = accept && !func;
    assign pal_we    = accept && func && ({1'b0, pal_index} < 9'(PALETTE_DEPTH));

    always_comb
    begin
        phase_eff  = start_of_image ? 2'd0 : phase_reg;
        phase_next = 2'd0;
        emit       = 1'b0;
        two        = 1'b0;
        kind       = K_I8;
        raw0       = {24'd0, data_byte};
        rd_index_a = data_byte;
        case (format_reg)
            FMT_RGBA16:
            begin
                kind       = K_5551;
                raw0       = {16'd0, held_reg[7:0], data_byte};
                emit       = (phase_eff != 2'd0);
                phase_next = emit ? 2'd0 : 2'd1;
            end
            FMT_RGBA32:
            begin
                kind       = K_RGBA32;
                raw0       = {held_reg, data_byte};
                emit       = (phase_eff == 2'd3);
                phase_next = emit ? 2'd0 : phase_eff + 2'd1;
            end
            FMT_IA4:
            begin
                kind = K_IA4;
                raw0 = {28'd0, data_byte[7:4]};
                emit = 1'b1;
                two  = 1'b1;
            end
            FMT_IA8:
            begin
                kind = K_IA8;
                emit = 1'b1;
            end
            FMT_IA16:
            begin
                kind       = K_IA16;
                raw0       = {16'd0, held_reg[7:0], data_byte};
                emit       = (phase_eff != 2'd0);
                phase_next = emit ? 2'd0 : 2'd1;
            end
            FMT_CI4:
            begin
                kind       = K_PAL;
                rd_index_a = {4'd0, data_byte[7:4]};
                emit       = 1'b1;
                two        = 1'b1;
            end
            FMT_CI8:
            begin
                kind = K_PAL;
                emit = 1'b1;
            end
            FMT_I4:
            begin
                kind = K_I4;
                raw0 = {28'd0, data_byte[7:4]};
                emit = 1'b1;
                two  = 1'b1;
            end
            FMT_I8:
            begin
                kind = K_I8;
                emit = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        oob0 = ({1'b0, rd_index_a} >= 9'(PALETTE_DEPTH));
        oob1 = ({5'd0, data_byte[3:0]} >= 9'(PALETTE_DEPTH));
    end

    tfr_ram #(
        .WIDTH(PAL_WIDTH),
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .we      (pal_we),
        .waddr   (pal_index[PAL_AW-1:0]),
        .wdata   (pal_color),
        .re      (data_item && emit),
        .raddr_a (rd_index_a[PAL_AW-1:0]),
        .raddr_b (PAL_AW'(data_byte[3:0])),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        if (s1_second_reg)
        begin
            pal_col = s1_oob1_reg ? '0 : rdata_b;
            raw_sel = {28'd0, s1_raw1_reg};
        end
        else
        begin
            pal_col = s1_oob0_reg ? '0 : rdata_a;
            raw_sel = s1_raw0_reg;
        end
        if (s1_kind_reg == K_PAL)
        begin
            raw_sel = {16'd0, pal_col};
        end
        pix_sel = expand(s1_kind_reg, raw_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg    <= FMT_RGBA16;
            phase_reg     <= 2'd0;
            held_reg      <= 24'd0;
            s1_valid_reg  <= 1'b0;
            s1_second_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                format_reg <= cfg_data;
            end
            if (data_item)
            begin
                phase_reg <= phase_next;
                held_reg  <= {held_reg[15:0], data_byte};
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_valid_reg && out_load && !s1_last)
            begin
                s1_second_reg <= 1'b1;
            end
            else if (s1_leave)
            begin
                s1_second_reg <= 1'b0;
            end
            if (accept)
            begin
                s1_valid_reg <= data_item && emit;
            end
            else if (s1_leave)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_two_reg  <= two;
            s1_kind_reg <= kind;
            s1_raw0_reg <= raw0;
            s1_raw1_reg <= data_byte[3:0];
            s1_oob0_reg <= oob0;
            s1_oob1_reg <= oob1;
        end
        if (out_load && s1_valid_reg)
        begin
            out_pix_reg  <= pix_sel;
            out_last_reg <= s1_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red         = out_pix_reg.red;
    assign green       = out_pix_reg.green;
    assign blue        = out_pix_reg.blue;
    assign alpha       = out_pix_reg.alpha;
    assign last_of_run = out_last_reg;

    a_second_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        s1_second_reg |-> (s1_valid_reg && s1_two_reg))
        else $error("second pixel pending on a one-pixel beat");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |-> in_stall)
        else $error("input taken while both stages are blocked");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_run) |=> (out_valid && last_of_run))
        else $error("second pixel of a byte did not follow the first");

endmodule

@@ design/tfr_ram.sv @@
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module tfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for texel_format_to_rgba32: a directed table, then random bursts in
// every texel format, each pixel beat checked against the table or an in-bench predictor.
// Depends on tfr_pkg and the texel_format_to_rgba32 RTL.
module tb_top;

    import tfr_pkg::*;

    localparam logic      FUNC_TEXEL       = 1'b0;
    localparam logic      FUNC_PALETTE     = 1'b1;
    localparam logic [3:0] FMT_UNUSED_FIRST = 4'd9;
    localparam logic [3:0] FMT_UNUSED_TOP   = 4'd15;
    localparam int        ITEM_TARGET      = 820;
    localparam int        DRAIN_SLACK      = 8;
    localparam int        LONG_HOLD        = 120;
    localparam int        CYCLE_LIMIT      = 300000;

    typedef struct packed {
        logic        func;
        logic [7:0]  data_byte;
        logic        sof;
        logic [7:0]  pal_index;
        logic [15:0] pal_color;
    } texel_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } pixel_t;

    typedef struct packed {
        logic        set_fmt;
        logic [3:0]  fmt;
        texel_item_t item;
        logic        typed;
        logic [1:0]  n_typed;
        pixel_t      px0;
        pixel_t      px1;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [3:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic func;
    logic [7:0] data_byte;
    logic start_of_image;
    logic [7:0] pal_index;
    logic [PAL_WIDTH-1:0] pal_color;
    logic out_valid;
    logic out_stall;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic last_of_run;

    logic [3:0]  fmt_now;
    logic [1:0]  byte_phase;
    logic [23:0] held_bytes;
    logic [15:0] palette_copy [PALETTE_DEPTH];
    bit          palette_loaded [PALETTE_DEPTH];

    pixel_t        expected_pixels [$];
    directed_row_t directed_rows [$];

    int mismatches;
    int pixels_checked;
    int texel_beats;
    int palette_beats;
    int settings_made;
    int burst_left;
    int holds_asked;
    int holds_done;
    int cycle_count;

    texel_format_to_rgba32 dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .data_byte(data_byte),
        .start_of_image(start_of_image),
        .pal_index(pal_index),
        .pal_color(pal_color),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .red(red),
        .green(green),
        .blue(blue),
        .alpha(alpha),
        .last_of_run(last_of_run)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [7:0] widen_five(input logic [4:0] v);
        int t;
        t = (v * 255) / 31;
        return t[7:0];
    endfunction

    function automatic pixel_t pix(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic [7:0] a,
                                   input logic last);
        return {r, g, b, a, last};
    endfunction

    function automatic pixel_t grey(input logic [7:0] v, input logic [7:0] a, input logic last);
        return {v, v, v, a, last};
    endfunction

    function automatic pixel_t from_5551(input logic [15:0] w, input logic last);
        return {widen_five(w[15:11]), widen_five(w[10:6]), widen_five(w[5:1]), {8{w[0]}}, last};
    endfunction

    task automatic unpack_texel(input texel_item_t it, output int n,
                                output pixel_t p0, output pixel_t p1);
        logic [23:0] prev;
        logic [3:0]  hi;
        logic [3:0]  lo;
        logic [7:0]  b;
        n = 0;
        p0 = '0;
        p1 = '0;
        b = it.data_byte;
        hi = b[7:4];
        lo = b[3:0];
        if (it.func == FUNC_PALETTE)
        begin
            palette_copy[it.pal_index] = it.pal_color;
            palette_loaded[it.pal_index] = 1'b1;
        end
        else
        begin
            if (it.sof)
                byte_phase = 2'd0;
            prev = held_bytes;
            held_bytes = {held_bytes[15:0], b};
            case (fmt_now)
                FMT_RGBA16, FMT_IA16:
                begin
                    if (byte_phase == 2'd0)
                        byte_phase = 2'd1;
                    else
                    begin
                        if (fmt_now == FMT_RGBA16)
                            p0 = from_5551({prev[7:0], b}, 1'b1);
                        else
                            p0 = grey(prev[7:0], b, 1'b1);
                        byte_phase = 2'd0;
                        n = 1;
                    end
                end
                FMT_RGBA32:
                begin
                    if (byte_phase != 2'd3)
                        byte_phase = byte_phase + 2'd1;
                    else
                    begin
                        p0 = pix(prev[23:16], prev[15:8], prev[7:0], b, 1'b1);
                        byte_phase = 2'd0;
                        n = 1;
                    end
                end
                FMT_IA4:
                begin
                    p0 = grey({5'd0, hi[3:1]} * 8'd36, {8{hi[0]}}, 1'b0);
                    p1 = grey({5'd0, lo[3:1]} * 8'd36, {8{lo[0]}}, 1'b1);
                    n = 2;
                end
                FMT_IA8:
                begin
                    p0 = grey({4'd0, hi} * 8'd17, {4'd0, lo} * 8'd17, 1'b1);
                    n = 1;
                end
                FMT_CI4:
                begin
                    p0 = from_5551(palette_copy[hi], 1'b0);
                    p1 = from_5551(palette_copy[lo], 1'b1);
                    n = 2;
                end
                FMT_CI8:
                begin
                    p0 = from_5551(palette_copy[b], 1'b1);
                    n = 1;
                end
                FMT_I4:
                begin
                    p0 = grey({4'd0, hi} * 8'd17, 8'hFF, 1'b0);
                    p1 = grey({4'd0, lo} * 8'd17, 8'hFF, 1'b1);
                    n = 2;
                end
                FMT_I8:
                begin
                    p0 = grey(b, 8'hFF, 1'b1);
                    n = 1;
                end
                default:
                begin
                    n = 0;
                end
            endcase
            if (fmt_now != FMT_RGBA16 && fmt_now != FMT_IA16 && fmt_now != FMT_RGBA32)
                byte_phase = 2'd0;
        end
    endtask

    function automatic texel_item_t tx(input logic [7:0] b, input logic sof);
        return {FUNC_TEXEL, b, sof, 8'h00, 16'h0000};
    endfunction

    function automatic texel_item_t pw(input logic [7:0] idx, input logic [15:0] col);
        return {FUNC_PALETTE, 8'h00, 1'b1, idx, col};
    endfunction

    function automatic directed_row_t tbl_row(input logic set_fmt, input logic [3:0] fmt,
                                             input texel_item_t it);
        directed_row_t r;
        r = '0;
        r.set_fmt = set_fmt;
        r.fmt = fmt;
        r.item = it;
        return r;
    endfunction

    function automatic directed_row_t with_pixels(input directed_row_t r, input logic [1:0] n,
                                                  input pixel_t p0, input pixel_t p1);
        directed_row_t t;
        t = r;
        t.typed = 1'b1;
        t.n_typed = n;
        t.px0 = p0;
        t.px1 = p1;
        return t;
    endfunction

    function automatic texel_item_t random_item();
        texel_item_t it;
        it.func = 1'($urandom_range(0, 1));
        it.data_byte = 8'($urandom_range(0, 255));
        it.sof = 1'($urandom_range(0, 1));
        it.pal_index = 8'($urandom_range(0, 255));
        it.pal_color = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic logic [3:0] format_code(input int k);
        case (k)
            0: return FMT_RGBA16;
            1: return FMT_RGBA32;
            2: return FMT_IA4;
            3: return FMT_IA8;
            4: return FMT_IA16;
            5: return FMT_CI4;
            6: return FMT_CI8;
            7: return FMT_I4;
            default: return FMT_I8;
        endcase
    endfunction

    function automatic int group_size(input logic [3:0] f);
        if (f == FMT_RGBA32)
            return 4;
        if (f == FMT_RGBA16 || f == FMT_IA16)
            return 2;
        return 1;
    endfunction

    // The sender offers one beat and returns at the edge that takes it, with valid still high.
    task automatic send_row(input directed_row_t r);
        int     n;
        pixel_t p0;
        pixel_t p1;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(60, 150);
            else
                burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        func <= r.item.func;
        data_byte <= r.item.data_byte;
        start_of_image <= r.item.sof;
        pal_index <= r.item.pal_index;
        pal_color <= r.item.pal_color;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (r.item.func == FUNC_PALETTE)
            palette_beats++;
        else
            texel_beats++;
        unpack_texel(r.item, n, p0, p1);
        if (r.typed)
        begin
            n = r.n_typed;
            p0 = r.px0;
            p1 = r.px1;
        end
        if (n > 0)
            expected_pixels.push_back(p0);
        if (n > 1)
            expected_pixels.push_back(p1);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic set_format(input logic [3:0] f);
        cfg_data <= f;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        fmt_now = f;
        settings_made++;
    endtask

    task automatic load_entry(input logic [7:0] idx);
        texel_item_t it;
        if (!palette_loaded[idx])
        begin
            it = random_item();
            it.func = FUNC_PALETTE;
            it.pal_index = idx;
            send_row(tbl_row(1'b0, fmt_now, it));
        end
    endtask

    task automatic random_run(input int count, input bit pause_mid);
        texel_item_t it;
        int          gsize;
        int          pos;
        gsize = group_size(fmt_now);
        pos = 0;
        for (int k = 0; k < count; k++)
        begin
            if (pause_mid && k == count / 2)
                go_idle();
            it = random_item();
            if ($urandom_range(0, 99) < 6)
                it.func = FUNC_PALETTE;
            else
            begin
                it.func = FUNC_TEXEL;
                if (pos == 0)
                    it.sof = ($urandom_range(0, 3) != 0);
                else
                    it.sof = ($urandom_range(0, 24) == 0);
                if (fmt_now == FMT_CI4)
                begin
                    load_entry({4'd0, it.data_byte[7:4]});
                    load_entry({4'd0, it.data_byte[3:0]});
                end
                else if (fmt_now == FMT_CI8)
                    load_entry(it.data_byte);
                pos = it.sof ? 1 : pos + 1;
                if (pos >= gsize)
                    pos = 0;
            end
            send_row(tbl_row(1'b0, fmt_now, it));
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("pixel %02h%02h%02h%02h with nothing expected",
                                          red, green, blue, alpha));
            else
            begin
                want = expected_pixels.pop_front();
                if (red !== want.red)
                    report_mismatch($sformatf("red got %02h want %02h", red, want.red));
                if (green !== want.green)
                    report_mismatch($sformatf("green got %02h want %02h", green, want.green));
                if (blue !== want.blue)
                    report_mismatch($sformatf("blue got %02h want %02h", blue, want.blue));
                if (alpha !== want.alpha)
                    report_mismatch($sformatf("alpha got %02h want %02h", alpha, want.alpha));
                if (last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run got %b want %b",
                                              last_of_run, want.last));
            end
            pixels_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d pixels outstanding",
                     cycle_count, expected_pixels.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver stalls at a randomly chosen rate per stretch, and holds off for a long run
    // of cycles whenever the stimulus side asks for it.
    initial
    begin
        int hold_left;
        int stretch_left;
        int stall_pct;
        hold_left = 0;
        stretch_left = 0;
        stall_pct = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done != holds_asked)
            begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (stretch_left == 0)
            begin
                stall_pct = 25 * $urandom_range(0, 3);
                stretch_left = $urandom_range(16, 160);
            end
            stretch_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        int         phase;
        logic [3:0] f;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = FMT_RGBA16;
        in_valid = 1'b0;
        func = FUNC_TEXEL;
        data_byte = 8'h00;
        start_of_image = 1'b0;
        pal_index = 8'h00;
        pal_color = '0;
        fmt_now = FMT_RGBA16;
        byte_phase = 2'd0;
        held_bytes = 24'h0;
        mismatches = 0;
        pixels_checked = 0;
        texel_beats = 0;
        palette_beats = 0;
        settings_made = 0;
        burst_left = 0;
        holds_asked = 0;
        holds_done = 0;
        cycle_count = 0;

        directed_rows.push_back(tbl_row(1'b0, FMT_RGBA16, tx(8'h00, 1'b1)));
        directed_rows.push_back(with_pixels(tbl_row(1'b0, FMT_RGBA16, tx(8'h01, 1'b0)),
            2'd1, pix(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1), '0));
        directed_rows.push_back(tbl_row(1'b0, FMT_RGBA16, tx(8'hFF, 1'b1)));
        directed_rows.push_back(tbl_row(1'b0, FMT_RGBA16, pw(8'h00, 16'hFFFF)));
        directed_rows.push_back(with_pixels(tbl_row(1'b0, FMT_RGBA16, tx(8'hFE, 1'b0)),
            2'd1, pix(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1), '0));
        directed_rows.push_back(tbl_row(1'b1, FMT_RGBA32, tx(8'hAA, 1'b1)));
        directed_rows.push_back(tbl_row(1'b0, FMT_RGBA32, tx(8'h12, 1'b1)));
        directed_rows.push_back(tbl_row(1'b0, FMT_RGBA32, tx(8'h34, 1'b0)));
        directed_rows.push_back(tbl_row(1'b0, FMT_RGBA32, tx(8'h56, 1'b0)));
        directed_rows.push_back(with_pixels(tbl_row(1'b0, FMT_RGBA32, tx(8'h78, 1'b0)),
            2'd1, pix(8'h12, 8'h34, 8'h56, 8'h78, 1'b1), '0));
        directed_rows.push_back(with_pixels(tbl_row(1'b1, FMT_IA4, tx(8'hF0, 1'b0)),
            2'd2, pix(8'hFC, 8'hFC, 8'hFC, 8'hFF, 1'b0),
            pix(8'h00, 8'h00, 8'h00, 8'h00, 1'b1)));
        directed_rows.push_back(tbl_row(1'b1, FMT_IA8, tx(8'h5A, 1'b1)));
        directed_rows.push_back(tbl_row(1'b1, FMT_IA16, tx(8'h80, 1'b1)));
        directed_rows.push_back(with_pixels(tbl_row(1'b0, FMT_IA16, tx(8'h7F, 1'b0)),
            2'd1, pix(8'h80, 8'h80, 8'h80, 8'h7F, 1'b1), '0));
        directed_rows.push_back(tbl_row(1'b1, FMT_CI4, pw(8'h0F, 16'h0001)));
        directed_rows.push_back(with_pixels(tbl_row(1'b0, FMT_CI4, tx(8'h0F, 1'b0)),
            2'd2, pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0),
            pix(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1)));
        directed_rows.push_back(tbl_row(1'b1, FMT_CI8, pw(8'hFF, 16'h8421)));
        directed_rows.push_back(tbl_row(1'b0, FMT_CI8, tx(8'hFF, 1'b0)));
        directed_rows.push_back(with_pixels(tbl_row(1'b1, FMT_I4, tx(8'h0F, 1'b0)),
            2'd2, pix(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0),
            pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1)));
        directed_rows.push_back(with_pixels(tbl_row(1'b1, FMT_I8, tx(8'h00, 1'b0)),
            2'd1, pix(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1), '0));
        directed_rows.push_back(with_pixels(tbl_row(1'b1, FMT_UNUSED_TOP, tx(8'h55, 1'b0)),
            2'd0, '0, '0));
        directed_rows.push_back(tbl_row(1'b1, FMT_RGBA16, tx(8'h12, 1'b1)));
        directed_rows.push_back(with_pixels(tbl_row(1'b1, FMT_IA16, tx(8'h34, 1'b0)),
            2'd1, pix(8'h12, 8'h12, 8'h12, 8'h34, 1'b1), '0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_fmt)
            begin
                go_idle();
                set_format(directed_rows[i].fmt);
            end
            send_row(directed_rows[i]);
        end

        phase = 0;
        while (texel_beats + palette_beats < ITEM_TARGET)
        begin
            go_idle();
            if (phase < 9)
                f = format_code(phase);
            else if ($urandom_range(0, 9) == 0)
                f = 4'($urandom_range(FMT_UNUSED_FIRST, FMT_UNUSED_TOP));
            else
                f = format_code($urandom_range(0, 8));
            set_format(f);
            if (phase % 6 == 2)
                holds_asked++;
            random_run($urandom_range(24, 96), phase % 6 == 4);
            phase++;
        end
        go_idle();

        $display("Covered %0d texel beats and %0d palette writes over %0d format settings.",
                 texel_beats, palette_beats, settings_made);
        $display("Checked %0d pixel beats with %0d mismatches.", pixels_checked, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
